// File: design/quic_cid_socket_steering_unit_assert.svh
// ----------------------------------------------------------------------------
// QUIC CID socket steering: assertion macros
// Shared concurrent assertion forms for the steering unit modules.
// ----------------------------------------------------------------------------
`ifndef QUIC_CID_SOCKET_STEERING_UNIT_ASSERT_SVH
`define QUIC_CID_SOCKET_STEERING_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside of reset
`define QCSS_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("qcss same-cycle check failed");

// Next-cycle implication, checked outside of reset
`define QCSS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("qcss next-cycle check failed");

`endif

// File: design/qcss_pkg.sv
// ----------------------------------------------------------------------------
// QUIC CID socket steering package
// Constants, codes and shared types of the steering unit.
// ----------------------------------------------------------------------------
package qcss_pkg;

  // Sizing
  localparam int MAX_SOCKETS      = 64;
  localparam int HEADER_WINDOW    = 32;
  localparam int UDP_HEADER_BYTES = 8;
  localparam int FULL_LENGTH      = UDP_HEADER_BYTES + HEADER_WINDOW;
  localparam int POS_W            = $clog2(FULL_LENGTH + 1);

  // Field widths
  localparam int BYTE_W      = 8;
  localparam int HASH_W      = 32;
  localparam int SEL_W       = 7;
  localparam int COUNT_W     = 7;
  localparam int MASK_W      = 64;
  localparam int SOCK_IDX_W  = 6;
  localparam int CNT_W       = 64;

  // Header layout (offsets inside the QUIC header)
  localparam int Q_OFF_HDR      = 0;
  localparam int Q_OFF_BYTE1    = 1;
  localparam int Q_OFF_MID_LO   = 2;
  localparam int Q_OFF_MID_HI   = 4;
  localparam int Q_OFF_DCID_LEN = 5;
  localparam int SCID_BASE      = 7;
  localparam int LONG_HEADER_BIT = 7;
  localparam logic [BYTE_W-1:0] HASH_LOW_MASK = 8'hFF;

  // Counter map
  localparam int CNT_DEPTH  = 67;
  localparam int CNT_ADDR_W = $clog2(CNT_DEPTH);
  localparam logic [CNT_ADDR_W-1:0] CNT_TOTAL      = CNT_ADDR_W'(64);
  localparam logic [CNT_ADDR_W-1:0] CNT_SHORT      = CNT_ADDR_W'(65);
  localparam logic [CNT_ADDR_W-1:0] CNT_SELECT_ERR = CNT_ADDR_W'(66);

  localparam logic [COUNT_W-1:0] DEFAULT_SOCKETS = COUNT_W'(4);

  // Job queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Modulo unit: one dividend bit per cycle
  localparam int DIV_STEPS = HASH_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 64;
  localparam logic [CFG_IDX_W-1:0] CFG_SOCKET_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESENT_MASK = 1'b1;

  typedef enum logic {
    REQ_PACKET  = 1'b0,
    REQ_COUNTER = 1'b1
  } req_kind_e;

  // One queued job: a finished datagram or a counter read
  typedef struct packed {
    req_kind_e             kind;
    logic [HASH_W-1:0]     dividend;
    logic                  short_fb;
    logic                  far_fb;
    logic [SEL_W-1:0]      sel;
  } job_t;

endpackage

// File: design/qcss_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module qcss_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 67
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: design/qcss_front.sv
// ----------------------------------------------------------------------------
// QUIC CID socket steering: front end
// Takes one byte per transfer, keeps the header bytes that matter and turns
// each finished datagram or counter read into a queued job.
// ----------------------------------------------------------------------------
module qcss_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        accept_i,
  input  logic                        req_type_i,
  input  logic [qcss_pkg::BYTE_W-1:0] data_byte_i,
  input  logic                        last_i,
  input  logic [qcss_pkg::HASH_W-1:0] flow_hash_i,
  input  logic [qcss_pkg::SEL_W-1:0]  counter_select_i,
  output logic                        job_we_o,
  output qcss_pkg::job_t              job_o
);

  logic [qcss_pkg::POS_W-1:0]  pos_q, pos_d;
  logic [qcss_pkg::BYTE_W-1:0] hdr_q, hdr_d;
  logic [qcss_pkg::BYTE_W-1:0] byte1_q, byte1_d;
  logic [qcss_pkg::BYTE_W-1:0] mid0_q, mid0_d;
  logic [qcss_pkg::BYTE_W-1:0] mid1_q, mid1_d;
  logic [qcss_pkg::BYTE_W-1:0] mid2_q, mid2_d;
  logic [qcss_pkg::BYTE_W-1:0] dcid_q, dcid_d;
  logic [qcss_pkg::BYTE_W-1:0] src_q, src_d;

  logic                        pkt_acc;
  logic                        in_win;
  logic [qcss_pkg::POS_W-1:0]  q_off;
  logic [qcss_pkg::BYTE_W-1:0] scid_off_cur;
  logic [qcss_pkg::BYTE_W-1:0] scid_off_new;
  logic [qcss_pkg::POS_W-1:0]  pos_next;
  logic                        is_short;
  logic                        is_long;
  logic                        is_far;
  logic [qcss_pkg::BYTE_W-1:0] shard;

  assign pkt_acc = accept_i && (qcss_pkg::req_kind_e'(req_type_i) == qcss_pkg::REQ_PACKET);
  assign in_win  = (pos_q >= qcss_pkg::POS_W'(qcss_pkg::UDP_HEADER_BYTES)) &&
                   (pos_q <  qcss_pkg::POS_W'(qcss_pkg::FULL_LENGTH));
  assign q_off   = pos_q - qcss_pkg::POS_W'(qcss_pkg::UDP_HEADER_BYTES);
  assign scid_off_cur = dcid_q + qcss_pkg::BYTE_W'(qcss_pkg::SCID_BASE);

  // Byte position, saturating at the end of the window
  assign pos_next = (pos_q < qcss_pkg::POS_W'(qcss_pkg::FULL_LENGTH)) ?
                    pos_q + qcss_pkg::POS_W'(1) : pos_q;

  // Capture the header bytes this byte lands on
  always_comb begin
    hdr_d   = hdr_q;
    byte1_d = byte1_q;
    mid0_d  = mid0_q;
    mid1_d  = mid1_q;
    mid2_d  = mid2_q;
    dcid_d  = dcid_q;
    src_d   = src_q;
    if (in_win) begin
      priority if (q_off == qcss_pkg::POS_W'(qcss_pkg::Q_OFF_HDR)) begin
        hdr_d = data_byte_i;
      end else if (q_off == qcss_pkg::POS_W'(qcss_pkg::Q_OFF_BYTE1)) begin
        byte1_d = data_byte_i;
      end else if (q_off == qcss_pkg::POS_W'(qcss_pkg::Q_OFF_MID_LO)) begin
        mid0_d = data_byte_i;
      end else if (q_off == qcss_pkg::POS_W'(qcss_pkg::Q_OFF_MID_LO + 1)) begin
        mid1_d = data_byte_i;
      end else if (q_off == qcss_pkg::POS_W'(qcss_pkg::Q_OFF_MID_HI)) begin
        mid2_d = data_byte_i;
      end else if (q_off == qcss_pkg::POS_W'(qcss_pkg::Q_OFF_DCID_LEN)) begin
        dcid_d = data_byte_i;
      end else if (qcss_pkg::BYTE_W'(q_off) == scid_off_cur) begin
        src_d = data_byte_i;
      end
    end
  end

  // Classify the datagram from the header as it stands after this byte
  assign is_short     = pos_next < qcss_pkg::POS_W'(qcss_pkg::FULL_LENGTH);
  assign is_long      = hdr_d[qcss_pkg::LONG_HEADER_BIT];
  assign scid_off_new = dcid_d + qcss_pkg::BYTE_W'(qcss_pkg::SCID_BASE);
  assign is_far       = is_long &&
                        (scid_off_new >= qcss_pkg::BYTE_W'(qcss_pkg::HEADER_WINDOW));

  // Source CID byte; a wrapped offset points back at an earlier byte
  always_comb begin
    priority if (!is_long) begin
      shard = byte1_d;
    end else if (scid_off_new == qcss_pkg::BYTE_W'(qcss_pkg::Q_OFF_HDR)) begin
      shard = hdr_d;
    end else if (scid_off_new == qcss_pkg::BYTE_W'(qcss_pkg::Q_OFF_BYTE1)) begin
      shard = byte1_d;
    end else if (scid_off_new == qcss_pkg::BYTE_W'(qcss_pkg::Q_OFF_MID_LO)) begin
      shard = mid0_d;
    end else if (scid_off_new == qcss_pkg::BYTE_W'(qcss_pkg::Q_OFF_MID_LO + 1)) begin
      shard = mid1_d;
    end else if (scid_off_new == qcss_pkg::BYTE_W'(qcss_pkg::Q_OFF_MID_HI)) begin
      shard = mid2_d;
    end else if (scid_off_new == qcss_pkg::BYTE_W'(qcss_pkg::Q_OFF_DCID_LEN)) begin
      shard = dcid_d;
    end else begin
      shard = src_d;
    end
  end

  // Job for the back end
  assign job_we_o = accept_i &&
                    ((qcss_pkg::req_kind_e'(req_type_i) == qcss_pkg::REQ_COUNTER) || last_i);

  always_comb begin
    job_o          = '0;
    job_o.kind     = qcss_pkg::req_kind_e'(req_type_i);
    job_o.sel      = counter_select_i;
    job_o.short_fb = is_short;
    job_o.far_fb   = !is_short && is_far;
    priority if (is_short) begin
      job_o.dividend = flow_hash_i;
    end else if (is_far) begin
      job_o.dividend = qcss_pkg::HASH_W'(flow_hash_i[qcss_pkg::BYTE_W-1:0] &
                                          qcss_pkg::HASH_LOW_MASK);
    end else begin
      job_o.dividend = qcss_pkg::HASH_W'(shard);
    end
  end

  // Datagram state; cleared after the last byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      hdr_q   <= '0;
      byte1_q <= '0;
      mid0_q  <= '0;
      mid1_q  <= '0;
      mid2_q  <= '0;
      dcid_q  <= '0;
      src_q   <= '0;
    end else if (pkt_acc) begin
      if (last_i) begin
        pos_q   <= '0;
        hdr_q   <= '0;
        byte1_q <= '0;
        mid0_q  <= '0;
        mid1_q  <= '0;
        mid2_q  <= '0;
        dcid_q  <= '0;
        src_q   <= '0;
      end else begin
        pos_q   <= pos_next;
        hdr_q   <= hdr_d;
        byte1_q <= byte1_d;
        mid0_q  <= mid0_d;
        mid1_q  <= mid1_d;
        mid2_q  <= mid2_d;
        dcid_q  <= dcid_d;
        src_q   <= src_d;
      end
    end
  end

endmodule

// File: design/qcss_fifo.sv
// ----------------------------------------------------------------------------
// QUIC CID socket steering: job queue
// Short first-in first-out queue of jobs between front and back end.
// ----------------------------------------------------------------------------
module qcss_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  qcss_pkg::job_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output qcss_pkg::job_t data_o
);

  qcss_pkg::job_t                entry_q [qcss_pkg::QUEUE_DEPTH];
  logic [qcss_pkg::QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [qcss_pkg::QCNT_W-1:0]   cnt_q;
  logic                          do_push, do_pop;

  assign full_o  = cnt_q == qcss_pkg::QCNT_W'(qcss_pkg::QUEUE_DEPTH);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = entry_q[rd_ptr_q];

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + qcss_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + qcss_pkg::QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + qcss_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - qcss_pkg::QCNT_W'(1);
      end
    end
  end

endmodule

// File: design/qcss_back.sv
// ----------------------------------------------------------------------------
// QUIC CID socket steering: back end
// Runs the modulo by the socket count, updates the event counters and holds
// the result register that the consumer pops.
// ----------------------------------------------------------------------------
`include "quic_cid_socket_steering_unit_assert.svh"

module qcss_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [qcss_pkg::COUNT_W-1:0]      socket_count_i,
  input  logic [qcss_pkg::MASK_W-1:0]       present_mask_i,
  input  logic                              q_empty_i,
  input  qcss_pkg::job_t                    q_data_i,
  output logic                              q_pop_o,
  input  logic                              pop_i,
  output logic                              empty_o,
  output logic                              result_kind_o,
  output logic [qcss_pkg::SOCK_IDX_W-1:0]   socket_index_o,
  output logic                              short_fallback_o,
  output logic                              far_cid_fallback_o,
  output logic                              select_failed_o,
  output logic [qcss_pkg::CNT_W-1:0]        counter_value_o
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_DIV  = 5'b00010,
    ST_RD   = 5'b00100,
    ST_WR   = 5'b01000,
    ST_OUT  = 5'b10000
  } back_state_e;

  back_state_e                        st_q, st_d;
  qcss_pkg::job_t                     job_q, job_d;
  logic [qcss_pkg::COUNT_W-1:0]       count_q, count_d;
  logic [qcss_pkg::COUNT_W-1:0]       rem_q, rem_d;
  logic [qcss_pkg::HASH_W-1:0]        sr_q, sr_d;
  logic [qcss_pkg::DIV_CNT_W-1:0]     div_cnt_q, div_cnt_d;
  logic                               fail_q, fail_d;
  logic [1:0]                         step_q, step_d;
  logic [qcss_pkg::CNT_ADDR_W-1:0]    addr_q, addr_d;
  logic [qcss_pkg::CNT_DEPTH-1:0]     vld_q;

  logic [qcss_pkg::COUNT_W-1:0]       count_eff;
  logic [qcss_pkg::COUNT_W-1:0]       rem_sh;
  logic [qcss_pkg::COUNT_W-1:0]       rem_step;
  logic                               in_range;
  logic [qcss_pkg::CNT_ADDR_W-1:0]    ram_raddr;
  logic [qcss_pkg::CNT_W-1:0]         ram_rdata;
  logic [qcss_pkg::CNT_W-1:0]         cur_val;
  logic                               ram_we;
  logic                               out_free;
  logic                               out_load;

  logic                               out_valid_q;
  logic                               out_kind_q;
  logic [qcss_pkg::SOCK_IDX_W-1:0]    out_idx_q;
  logic                               out_short_q;
  logic                               out_far_q;
  logic                               out_fail_q;
  logic [qcss_pkg::CNT_W-1:0]         out_val_q;

  // Effective socket count: zero means the default, clamp to the maximum
  always_comb begin
    priority if (socket_count_i == '0) begin
      count_eff = qcss_pkg::DEFAULT_SOCKETS;
    end else if (socket_count_i > qcss_pkg::COUNT_W'(qcss_pkg::MAX_SOCKETS)) begin
      count_eff = qcss_pkg::COUNT_W'(qcss_pkg::MAX_SOCKETS);
    end else begin
      count_eff = socket_count_i;
    end
  end

  // One restoring modulo step
  assign rem_sh   = {rem_q[qcss_pkg::COUNT_W-2:0], sr_q[qcss_pkg::HASH_W-1]};
  assign rem_step = (rem_sh >= count_q) ? rem_sh - count_q : rem_sh;

  // Counter memory; entries never written read as zero
  assign in_range  = addr_q < qcss_pkg::CNT_ADDR_W'(qcss_pkg::CNT_DEPTH);
  assign ram_raddr = in_range ? addr_q : '0;
  assign cur_val   = (in_range && vld_q[ram_raddr]) ? ram_rdata : '0;
  assign ram_we    = st_q == ST_WR;

  qcss_ram #(
    .WIDTH (qcss_pkg::CNT_W),
    .DEPTH (qcss_pkg::CNT_DEPTH)
  ) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (addr_q),
    .wdata_i (cur_val + qcss_pkg::CNT_W'(1)),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_free = !out_valid_q || pop_i;
  assign out_load = (st_q == ST_OUT) && out_free;
  assign q_pop_o  = (st_q == ST_IDLE) && !q_empty_i;

  // Sequencer
  always_comb begin
    st_d      = st_q;
    job_d     = job_q;
    count_d   = count_q;
    rem_d     = rem_q;
    sr_d      = sr_q;
    div_cnt_d = div_cnt_q;
    fail_d    = fail_q;
    step_d    = step_q;
    addr_d    = addr_q;
    unique case (st_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          job_d     = q_data_i;
          count_d   = count_eff;
          rem_d     = '0;
          sr_d      = q_data_i.dividend;
          div_cnt_d = '0;
          step_d    = '0;
          if (q_data_i.kind == qcss_pkg::REQ_COUNTER) begin
            addr_d = q_data_i.sel;
            st_d   = ST_RD;
          end else begin
            st_d = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        rem_d     = rem_step;
        sr_d      = sr_q << 1;
        div_cnt_d = div_cnt_q + qcss_pkg::DIV_CNT_W'(1);
        if (div_cnt_q == qcss_pkg::DIV_CNT_W'(qcss_pkg::DIV_STEPS - 1)) begin
          fail_d = !present_mask_i[rem_step[qcss_pkg::SOCK_IDX_W-1:0]];
          addr_d = qcss_pkg::CNT_TOTAL;
          st_d   = ST_RD;
        end
      end
      ST_RD: begin
        st_d = (job_q.kind == qcss_pkg::REQ_COUNTER) ? ST_OUT : ST_WR;
      end
      ST_WR: begin
        // Counter sequence: total, then short or socket, then select error if the select failed
        unique case (step_q)
          2'd0: begin
            addr_d = job_q.short_fb ? qcss_pkg::CNT_SHORT :
                     qcss_pkg::CNT_ADDR_W'(rem_q[qcss_pkg::SOCK_IDX_W-1:0]);
            step_d = 2'd1;
            st_d   = ST_RD;
          end
          2'd1: begin
            if (fail_q) begin
              addr_d = qcss_pkg::CNT_SELECT_ERR;
              step_d = 2'd2;
              st_d   = ST_RD;
            end else begin
              st_d = ST_OUT;
            end
          end
          default: begin
            st_d = ST_OUT;
          end
        endcase
      end
      ST_OUT: begin
        if (out_free) begin
          st_d = ST_IDLE;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_IDLE;
      div_cnt_q <= '0;
      step_q    <= '0;
      count_q   <= qcss_pkg::DEFAULT_SOCKETS;
      rem_q     <= '0;
      vld_q     <= '0;
    end else begin
      st_q      <= st_d;
      div_cnt_q <= div_cnt_d;
      step_q    <= step_d;
      count_q   <= count_d;
      rem_q     <= rem_d;
      if (ram_we) begin
        vld_q[addr_q] <= 1'b1;
      end
    end
  end

  // Job payload
  always_ff @(posedge clk_i) begin
    job_q  <= job_d;
    sr_q   <= sr_d;
    fail_q <= fail_d;
    addr_q <= addr_d;
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (pop_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_kind_q <= job_q.kind;
      if (job_q.kind == qcss_pkg::REQ_COUNTER) begin
        out_idx_q   <= '0;
        out_short_q <= 1'b0;
        out_far_q   <= 1'b0;
        out_fail_q  <= 1'b0;
        out_val_q   <= cur_val;
      end else begin
        out_idx_q   <= rem_q[qcss_pkg::SOCK_IDX_W-1:0];
        out_short_q <= job_q.short_fb;
        out_far_q   <= job_q.far_fb;
        out_fail_q  <= fail_q;
        out_val_q   <= '0;
      end
    end
  end

  assign empty_o            = !out_valid_q;
  assign result_kind_o      = out_kind_q;
  assign socket_index_o     = out_idx_q;
  assign short_fallback_o   = out_short_q;
  assign far_cid_fallback_o = out_far_q;
  assign select_failed_o    = out_fail_q;
  assign counter_value_o    = out_val_q;

  // Checks
  `QCSS_ASSERT_SAME(a_rem_below_count, clk_i, rst_ni, st_q == ST_DIV, rem_q < count_q)
  `QCSS_ASSERT_SAME(a_wr_in_range, clk_i, rst_ni, ram_we, addr_q < qcss_pkg::CNT_ADDR_W'(qcss_pkg::CNT_DEPTH))
  `QCSS_ASSERT_SAME(a_take_nonempty, clk_i, rst_ni, q_pop_o, !q_empty_i)
  `QCSS_ASSERT_NEXT(a_out_loads, clk_i, rst_ni, out_load, out_valid_q)
  `QCSS_ASSERT_SAME(a_read_no_route, clk_i, rst_ni, out_valid_q && out_kind_q, (out_idx_q == '0) && !out_short_q && !out_far_q && !out_fail_q)

endmodule

// File: design/quic_cid_socket_steering_unit.sv
// ----------------------------------------------------------------------------
// QUIC connection-ID socket steering unit
// Steers UDP datagrams, fed one byte per transfer, to a socket index and
// keeps readable event counters.
// ----------------------------------------------------------------------------
// Datagram bytes are taken one per cycle while the job queue has room; a byte
// that is not the last one only updates the header capture. Each last byte
// and each counter read becomes a job in a four-entry queue. The back end
// serves one job at a time: a routing decision pops the queue, runs the
// bit-serial modulo by the socket count, updates each counter with a read and
// a write through the single counter RAM port and loads the result; a counter
// read pops the queue, reads the RAM and loads the result. One result waits in
// an output register while the next job proceeds. Counters reset to zero at
// once (per-entry valid bits), so no clearing pass follows reset.
module quic_cid_socket_steering_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration
  input  logic                              cfg_we_i,
  input  logic [qcss_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [qcss_pkg::CFG_W-1:0]        cfg_data_i,
  // Input items
  input  logic                              push,
  output logic                              full,
  input  logic                              req_type_i,
  input  logic [qcss_pkg::BYTE_W-1:0]       data_byte_i,
  input  logic                              last_i,
  input  logic [qcss_pkg::HASH_W-1:0]       flow_hash_i,
  input  logic [qcss_pkg::SEL_W-1:0]        counter_select_i,
  // Results
  output logic                              empty,
  input  logic                              pop,
  output logic                              result_kind_o,
  output logic [qcss_pkg::SOCK_IDX_W-1:0]   socket_index_o,
  output logic                              short_fallback_o,
  output logic                              far_cid_fallback_o,
  output logic                              select_failed_o,
  output logic [qcss_pkg::CNT_W-1:0]        counter_value_o
);

  logic [qcss_pkg::COUNT_W-1:0] socket_count_q;
  logic [qcss_pkg::MASK_W-1:0]  present_mask_q;

  logic           accept;
  logic           job_we;
  qcss_pkg::job_t job_in;
  qcss_pkg::job_t job_out;
  logic           q_full;
  logic           q_empty;
  logic           q_pop;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      socket_count_q <= qcss_pkg::DEFAULT_SOCKETS;
      present_mask_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == qcss_pkg::CFG_SOCKET_COUNT) begin
        socket_count_q <= cfg_data_i[qcss_pkg::COUNT_W-1:0];
      end else begin
        present_mask_q <= cfg_data_i[qcss_pkg::MASK_W-1:0];
      end
    end
  end

  assign full   = q_full;
  assign accept = push && !q_full;

  qcss_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (accept),
    .req_type_i       (req_type_i),
    .data_byte_i      (data_byte_i),
    .last_i           (last_i),
    .flow_hash_i      (flow_hash_i),
    .counter_select_i (counter_select_i),
    .job_we_o         (job_we),
    .job_o            (job_in)
  );

  qcss_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_we),
    .data_i  (job_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (job_out)
  );

  qcss_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .socket_count_i     (socket_count_q),
    .present_mask_i     (present_mask_q),
    .q_empty_i          (q_empty),
    .q_data_i           (job_out),
    .q_pop_o            (q_pop),
    .pop_i              (pop),
    .empty_o            (empty),
    .result_kind_o      (result_kind_o),
    .socket_index_o     (socket_index_o),
    .short_fallback_o   (short_fallback_o),
    .far_cid_fallback_o (far_cid_fallback_o),
    .select_failed_o    (select_failed_o),
    .counter_value_o    (counter_value_o)
  );

endmodule

// File: verif/quic_cid_socket_steering_unit_tb.sv
// ----------------------------------------------------------------------------
// QUIC CID socket steering unit testbench
// Feeds datagrams byte by byte and counter reads into the steering unit,
// predicts every routing decision and counter value in a local copy of the
// steering state, and checks each result transfer in order. Both sides of the
// queue interface idle in random bursts, except in the last phase.
// ----------------------------------------------------------------------------
module quic_cid_socket_steering_unit_tb;
  import qcss_pkg::*;

  localparam int LIMIT_CYCLES = 600000;
  localparam int SETTLE       = 48;   // longer than one routing job
  localparam int PHASE_ITEMS  = 110;
  localparam int PHASES       = 7;
  localparam logic [MASK_W-1:0] ALL_PRESENT = '1;

  typedef struct {
    req_kind_e          kind;
    logic [BYTE_W-1:0]  data;
    logic               last;
    logic [HASH_W-1:0]  hash;
    logic [SEL_W-1:0]   sel;
  } steer_item_t;

  typedef struct {
    req_kind_e              kind;
    logic [SOCK_IDX_W-1:0]  sock;
    logic                   short_fb;
    logic                   far_fb;
    logic                   fail;
    logic [CNT_W-1:0]       cnt;
  } steer_result_t;

  // DUT signals
  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CFG_IDX_W-1:0]   cfg_idx_i;
  logic [CFG_W-1:0]       cfg_data_i;
  logic                   push;
  logic                   full;
  logic                   req_type_i;
  logic [BYTE_W-1:0]      data_byte_i;
  logic                   last_i;
  logic [HASH_W-1:0]      flow_hash_i;
  logic [SEL_W-1:0]       counter_select_i;
  logic                   empty;
  logic                   pop;
  logic                   result_kind_o;
  logic [SOCK_IDX_W-1:0]  socket_index_o;
  logic                   short_fallback_o;
  logic                   far_cid_fallback_o;
  logic                   select_failed_o;
  logic [CNT_W-1:0]       counter_value_o;

  // Local copy of the steering state
  logic [COUNT_W-1:0]     sock_count;
  logic [MASK_W-1:0]      present_mask;
  int                     rx_pos;
  logic [BYTE_W-1:0]      hdr_byte;
  logic [BYTE_W-1:0]      cid1_byte;
  logic [BYTE_W-1:0]      mid_bytes [3];
  logic [BYTE_W-1:0]      cid_len_byte;
  logic [BYTE_W-1:0]      scid_byte;
  logic [CNT_W-1:0]       event_cnt [CNT_DEPTH];

  steer_result_t          outcome_q [$];

  // Run bookkeeping
  bit  calm;
  int  cycles = 0;
  int  items_sent;
  int  mismatches;
  int  stray_results;
  int  decisions_seen;
  int  reads_seen;
  int  short_routes;
  int  far_routes;
  int  failed_routes;
  int  pop_hold;

  steer_result_t got_res;
  steer_result_t want_res;

  quic_cid_socket_steering_unit i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .push               (push),
    .full               (full),
    .req_type_i         (req_type_i),
    .data_byte_i        (data_byte_i),
    .last_i             (last_i),
    .flow_hash_i        (flow_hash_i),
    .counter_select_i   (counter_select_i),
    .empty              (empty),
    .pop                (pop),
    .result_kind_o      (result_kind_o),
    .socket_index_o     (socket_index_o),
    .short_fallback_o   (short_fallback_o),
    .far_cid_fallback_o (far_cid_fallback_o),
    .select_failed_o    (select_failed_o),
    .counter_value_o    (counter_value_o)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("quic_cid_socket_steering_unit_tb NOT OK");
      $finish;
    end
  end

  // QUIC header byte at a given offset, as captured so far
  function automatic logic [BYTE_W-1:0] captured_byte(input int off);
    if (off == Q_OFF_HDR) return hdr_byte;
    if (off == Q_OFF_BYTE1) return cid1_byte;
    if (off >= Q_OFF_MID_LO && off <= Q_OFF_MID_HI) return mid_bytes[off - Q_OFF_MID_LO];
    if (off == Q_OFF_DCID_LEN) return cid_len_byte;
    return scid_byte;
  endfunction

  function automatic void clear_capture();
    rx_pos       = 0;
    hdr_byte     = '0;
    cid1_byte    = '0;
    mid_bytes    = '{default: '0};
    cid_len_byte = '0;
    scid_byte    = '0;
  endfunction

  // Advance the steering state by one accepted item; queue any result it causes
  function automatic void steer_item(input steer_item_t it);
    steer_result_t r;
    int q;
    int n;
    int off;
    int shard;
    int idx;
    r = '{kind: REQ_PACKET, sock: '0, short_fb: 1'b0, far_fb: 1'b0, fail: 1'b0, cnt: '0};
    if (it.kind == REQ_COUNTER) begin
      r.kind = REQ_COUNTER;
      if (it.sel < CNT_DEPTH) r.cnt = event_cnt[it.sel];
      outcome_q.push_back(r);
      return;
    end
    // header capture inside the window
    if (rx_pos >= UDP_HEADER_BYTES && rx_pos < FULL_LENGTH) begin
      q = rx_pos - UDP_HEADER_BYTES;
      if (q == Q_OFF_HDR) hdr_byte = it.data;
      else if (q == Q_OFF_BYTE1) cid1_byte = it.data;
      else if (q <= Q_OFF_MID_HI) mid_bytes[q - Q_OFF_MID_LO] = it.data;
      else if (q == Q_OFF_DCID_LEN) cid_len_byte = it.data;
      else if (q == ((SCID_BASE + int'(cid_len_byte)) & 255)) scid_byte = it.data;
    end
    if (rx_pos < FULL_LENGTH) rx_pos++;
    if (!it.last) return;

    n = (sock_count == 0) ? int'(DEFAULT_SOCKETS) : int'(sock_count);
    if (n > MAX_SOCKETS) n = MAX_SOCKETS;
    event_cnt[CNT_TOTAL]++;
    if (rx_pos < FULL_LENGTH) begin
      r.short_fb = 1'b1;
      event_cnt[CNT_SHORT]++;
      idx = int'({32'b0, it.hash} % n);
      short_routes++;
    end else begin
      if (hdr_byte[LONG_HEADER_BIT]) begin
        off = (SCID_BASE + int'(cid_len_byte)) & 255;
        if (off < HEADER_WINDOW) begin
          shard = int'(captured_byte(off));
        end else begin
          r.far_fb = 1'b1;
          shard = int'(it.hash & 32'(HASH_LOW_MASK)) % n;
          far_routes++;
        end
      end else begin
        shard = int'(cid1_byte);
      end
      idx = shard % n;
      event_cnt[idx]++;
    end
    r.sock = SOCK_IDX_W'(idx);
    if (!present_mask[idx]) begin
      r.fail = 1'b1;
      event_cnt[CNT_SELECT_ERR]++;
      failed_routes++;
    end
    clear_capture();
    outcome_q.push_back(r);
  endfunction

  // Send one item; called and returns at a falling edge, push left high
  task automatic send_item(input steer_item_t it);
    if (!calm && $urandom_range(0, 7) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk_i);
    end
    push             <= 1'b1;
    req_type_i       <= it.kind;
    data_byte_i      <= it.data;
    last_i           <= it.last;
    flow_hash_i      <= it.hash;
    counter_select_i <= it.sel;
    do @(posedge clk_i); while (full);
    steer_item(it);
    items_sent++;
    @(negedge clk_i);
  endtask

  function automatic logic [SEL_W-1:0] pick_counter();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return SEL_W'($urandom_range(CNT_DEPTH, 127));
    if (roll <= 3) return SEL_W'($urandom_range(CNT_TOTAL, CNT_SELECT_ERR));
    return SEL_W'($urandom_range(0, MAX_SOCKETS - 1));
  endfunction

  task automatic send_counter_read(input logic [SEL_W-1:0] sel);
    steer_item_t it;
    it.kind = REQ_COUNTER;
    it.data = BYTE_W'($urandom);
    it.last = 1'($urandom);
    it.hash = $urandom;
    it.sel  = sel;
    send_item(it);
  endtask

  // One datagram of len bytes; counter reads slip in at read_pct percent
  task automatic send_datagram(input int len, input logic [BYTE_W-1:0] hdr,
                               input logic [BYTE_W-1:0] b1, input logic [BYTE_W-1:0] dcid,
                               input logic [HASH_W-1:0] hash, input int read_pct);
    steer_item_t it;
    int p;
    for (p = 0; p < len; p++) begin
      if ($urandom_range(0, 99) < read_pct) send_counter_read(pick_counter());
      it.kind = REQ_PACKET;
      it.data = BYTE_W'($urandom);
      if (p == UDP_HEADER_BYTES + Q_OFF_HDR) it.data = hdr;
      if (p == UDP_HEADER_BYTES + Q_OFF_BYTE1) it.data = b1;
      if (p == UDP_HEADER_BYTES + Q_OFF_DCID_LEN) it.data = dcid;
      it.last = (p == len - 1);
      it.hash = it.last ? hash : $urandom;
      it.sel  = SEL_W'($urandom);
      send_item(it);
    end
  endtask

  // Let every expected result arrive, then let the back end go quiet
  task automatic drain();
    push <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  // Both registers, written while the block is idle
  task automatic set_steering(input logic [COUNT_W-1:0] count, input logic [MASK_W-1:0] mask);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_SOCKET_COUNT;
    cfg_data_i <= CFG_W'(count);
    @(negedge clk_i);
    sock_count  = count;
    cfg_idx_i  <= CFG_PRESENT_MASK;
    cfg_data_i <= mask;
    @(negedge clk_i);
    present_mask = mask;
    cfg_we_i <= 1'b0;
  endtask

  // Result side: random pop stalls
  initial begin
    pop <= 1'b0;
    pop_hold = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (pop_hold > 0) begin
        pop_hold--;
        pop <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        pop_hold = $urandom_range(1, 10) - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Result check on each result transfer
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      got_res.kind     = req_kind_e'(result_kind_o);
      got_res.sock     = socket_index_o;
      got_res.short_fb = short_fallback_o;
      got_res.far_fb   = far_cid_fallback_o;
      got_res.fail     = select_failed_o;
      got_res.cnt      = counter_value_o;
      if (outcome_q.size() == 0) begin
        stray_results++;
        $display("unexpected result: kind %0d sock %0d cnt %0h",
                 got_res.kind, got_res.sock, got_res.cnt);
      end else begin
        want_res = outcome_q.pop_front();
        if (want_res.kind == REQ_COUNTER) reads_seen++;
        else decisions_seen++;
        if (got_res.kind !== want_res.kind || got_res.sock !== want_res.sock ||
            got_res.short_fb !== want_res.short_fb || got_res.far_fb !== want_res.far_fb ||
            got_res.fail !== want_res.fail || got_res.cnt !== want_res.cnt) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp kind %0d sock %0d short %0b far %0b fail %0b cnt %0h",
                     want_res.kind, want_res.sock, want_res.short_fb, want_res.far_fb,
                     want_res.fail, want_res.cnt,
                     " | got kind %0d sock %0d short %0b far %0b fail %0b cnt %0h",
                     got_res.kind, got_res.sock, got_res.short_fb, got_res.far_fb,
                     got_res.fail, got_res.cnt);
        end
      end
    end
  end

  // Counter map right after reset, including out-of-range selects
  task automatic test_counter_map();
    send_counter_read(SEL_W'(0));
    send_counter_read(SEL_W'(MAX_SOCKETS - 1));
    send_counter_read(CNT_TOTAL);
    send_counter_read(CNT_SHORT);
    send_counter_read(CNT_SELECT_ERR);
    send_counter_read(SEL_W'(CNT_DEPTH));
    send_counter_read('1);
    drain();
  endtask

  // Short datagrams under the reset setting: hash routing, empty mask
  task automatic test_short_datagram();
    send_datagram(1, 8'h00, 8'h00, 8'h00, '0, 0);
    send_datagram(FULL_LENGTH - 1, 8'hFF, 8'hFF, 8'hFF, '1, 0);
    send_counter_read(CNT_SHORT);
    send_counter_read(CNT_SELECT_ERR);
    drain();
  endtask

  // Long headers: CID offset inside, at the edge of, beyond and wrapped into the window
  task automatic test_long_header();
    set_steering(COUNT_W'(MAX_SOCKETS), ALL_PRESENT);
    send_datagram(FULL_LENGTH, 8'hFF, 8'h11, 8'd0, $urandom, 0);
    send_datagram(FULL_LENGTH, 8'h80, 8'h22, 8'(HEADER_WINDOW - SCID_BASE - 1), $urandom, 0);
    send_datagram(FULL_LENGTH, 8'hC0, 8'h33, 8'(HEADER_WINDOW - SCID_BASE), '1, 0);
    send_datagram(FULL_LENGTH + 30, 8'h81, 8'h44, 8'd255, $urandom, 0);
    send_datagram(FULL_LENGTH, 8'hBF, 8'h55, 8'd249, $urandom, 0);
    send_datagram(FULL_LENGTH, 8'hE5, 8'h66, 8'd250, $urandom, 0);
    send_datagram(FULL_LENGTH, 8'hF0, 8'h77, 8'd253, $urandom, 0);
    drain();
  endtask

  // Short headers: byte 1 decides
  task automatic test_short_header();
    set_steering(COUNT_W'(7), {$urandom, $urandom});
    send_datagram(FULL_LENGTH, 8'h00, 8'hFF, 8'hFF, $urandom, 0);
    send_datagram(FULL_LENGTH + 40, 8'h7F, 8'h00, 8'h00, $urandom, 0);
    drain();
  endtask

  // Socket count of zero, one and above the maximum
  task automatic test_socket_count();
    logic [COUNT_W-1:0] counts [4];
    int k;
    counts = '{COUNT_W'(0), COUNT_W'(1), COUNT_W'(MAX_SOCKETS + 1), '1};
    for (k = 0; k < 4; k++) begin
      set_steering(counts[k], (k % 2 == 0) ? ALL_PRESENT : {$urandom, $urandom});
      send_datagram(FULL_LENGTH, 8'h3C, 8'hFE, 8'h00, '1, 0);
      send_datagram(5, 8'h00, 8'h00, 8'h00, '1, 0);
      drain();
    end
  endtask

  // Counter reads interleaved inside datagrams
  task automatic test_read_mid_datagram();
    set_steering(COUNT_W'(16), ALL_PRESENT);
    send_datagram(FULL_LENGTH + 4, 8'h80, 8'h12, 8'd10, $urandom, 30);
    send_datagram(20, 8'h00, 8'h00, 8'h00, $urandom, 30);
    send_counter_read(CNT_TOTAL);
    send_counter_read(SEL_W'(0));
    drain();
  endtask

  // Random phases, each under its own setting; the last one without idling
  task automatic test_random_traffic();
    logic [COUNT_W-1:0] count;
    logic [MASK_W-1:0] mask;
    logic [BYTE_W-1:0] dcid;
    int phase;
    int stop_at;
    int len;
    int roll;
    for (phase = 0; phase < PHASES; phase++) begin
      calm = (phase == PHASES - 1);
      case ($urandom_range(0, 4))
        0: count = '0;
        1: count = COUNT_W'($urandom_range(1, 4));
        2: count = COUNT_W'($urandom_range(MAX_SOCKETS - 1, MAX_SOCKETS + 1));
        3: count = '1;
        default: count = COUNT_W'($urandom);
      endcase
      case ($urandom_range(0, 3))
        0: mask = '0;
        1: mask = ALL_PRESENT;
        2: mask = {$urandom, $urandom} & {$urandom, $urandom};
        default: mask = {$urandom, $urandom};
      endcase
      set_steering(count, mask);
      stop_at = items_sent + PHASE_ITEMS;
      while (items_sent < stop_at) begin
        roll = $urandom_range(0, 9);
        if (roll == 0) begin
          send_counter_read(pick_counter());
        end else begin
          if (roll <= 2) len = $urandom_range(1, FULL_LENGTH - 1);
          else if (roll == 3) len = $urandom_range(FULL_LENGTH, 100);
          else len = $urandom_range(FULL_LENGTH, FULL_LENGTH + 6);
          roll = $urandom_range(0, 9);
          if (roll < 4) dcid = BYTE_W'($urandom_range(0, HEADER_WINDOW - SCID_BASE - 1));
          else if (roll < 7) dcid = BYTE_W'($urandom_range(HEADER_WINDOW - SCID_BASE, 248));
          else dcid = BYTE_W'($urandom_range(249, 255));
          send_datagram(len, BYTE_W'($urandom), BYTE_W'($urandom), dcid, $urandom, 4);
        end
      end
      drain();
    end
  endtask

  // Main sequence
  initial begin
    rst_ni           <= 1'b0;
    cfg_we_i         <= 1'b0;
    cfg_idx_i        <= CFG_SOCKET_COUNT;
    cfg_data_i       <= '0;
    push             <= 1'b0;
    req_type_i       <= REQ_PACKET;
    data_byte_i      <= '0;
    last_i           <= 1'b0;
    flow_hash_i      <= '0;
    counter_select_i <= '0;
    items_sent     = 0;
    mismatches     = 0;
    stray_results  = 0;
    decisions_seen = 0;
    reads_seen     = 0;
    short_routes   = 0;
    far_routes     = 0;
    failed_routes  = 0;
    calm           = 1'b0;
    sock_count     = DEFAULT_SOCKETS;
    present_mask   = '0;
    event_cnt      = '{default: '0};
    clear_capture();
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_counter_map();
    test_short_datagram();
    test_long_header();
    test_short_header();
    test_socket_count();
    test_read_mid_datagram();
    test_random_traffic();

    $display("%0d items sent; %0d routing decisions and %0d counter reads checked",
             items_sent, decisions_seen, reads_seen);
    $display("%0d hash routed short datagrams, %0d far CID fallbacks, %0d absent sockets",
             short_routes, far_routes, failed_routes);
    if (mismatches == 0 && stray_results == 0 && outcome_q.size() == 0) begin
      $display("quic_cid_socket_steering_unit_tb OK");
    end else begin
      $display("%0d mismatches, %0d unexpected, %0d missing",
               mismatches, stray_results, outcome_q.size());
      $display("quic_cid_socket_steering_unit_tb NOT OK");
    end
    $finish;
  end

endmodule
